// ===== hdl/lsfe_pkg.sv =====
// Package for the LED strip frame store and emitter.
// Holds the stream field layout, the command codes and the shared command type.
// No dependencies.
package lsfe_pkg;

    localparam int KIND_W      = 3;
    localparam int IDX_IN_W    = 4;
    localparam int BRIGHT_W    = 5;
    localparam int COLOR_W     = 8;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam int KIND_LSB   = 0;
    localparam int IDX_LSB    = KIND_LSB + KIND_W;
    localparam int BRIGHT_LSB = IDX_LSB + IDX_IN_W;
    localparam int RED_LSB    = BRIGHT_LSB + BRIGHT_W;
    localparam int GREEN_LSB  = RED_LSB + COLOR_W;
    localparam int BLUE_LSB   = GREEN_LSB + COLOR_W;

    localparam logic [KIND_W-1:0] KIND_SET_ONE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET_ALL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RAISE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOWER   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMIT    = 3'd4;

    localparam logic [7:0]         LED_WORD_MARK = 8'hE0;
    localparam logic [COLOR_W-1:0] COLOR_MAX     = 8'hFF;

    typedef enum logic [2:0] {
        OP_SET_ONE = 3'd0,
        OP_SET_ALL = 3'd1,
        OP_RAISE   = 3'd2,
        OP_LOWER   = 3'd3,
        OP_EMIT    = 3'd4
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [IDX_IN_W-1:0] led_index;
        logic [BRIGHT_W-1:0] bright;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
    } cmd_t;

    typedef struct packed {
        logic [BRIGHT_W-1:0] bright;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
    } entry_t;

endpackage

// ===== hdl/lsfe_front.sv =====
// Command front end: accepts stream commands, drops meaningless ones and queues the rest.
// Depends on lsfe_pkg.
module lsfe_front
    import lsfe_pkg::*;
#(
    parameter int LED_COUNT = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // kind, led_index, bright_level, red_value, green_value, blue_value, zero pad
    input  logic [IN_TDATA_W-1:0] s_tdata,
    output logic                  q_valid,
    input  logic                  q_ready,
    output cmd_t                  q_cmd
);

    localparam int DEPTH = 2;

    cmd_t              slot_reg [DEPTH];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    logic [KIND_W-1:0]   in_kind;
    logic [IDX_IN_W-1:0] in_idx;
    cmd_t                in_cmd;
    logic                keep;
    logic                push;
    logic                pop;

    assign in_kind = s_tdata[KIND_LSB +: KIND_W];
    assign in_idx  = s_tdata[IDX_LSB +: IDX_IN_W];

    always_comb
    begin
        in_cmd.led_index = in_idx;
        in_cmd.bright    = s_tdata[BRIGHT_LSB +: BRIGHT_W];
        in_cmd.red       = s_tdata[RED_LSB +: COLOR_W];
        in_cmd.green     = s_tdata[GREEN_LSB +: COLOR_W];
        in_cmd.blue      = s_tdata[BLUE_LSB +: COLOR_W];
        keep             = 1'b1;
        case (in_kind)
            KIND_SET_ONE:
            begin
                in_cmd.op = OP_SET_ONE;
                keep      = (32'(in_idx) < LED_COUNT);
            end
            KIND_SET_ALL: in_cmd.op = OP_SET_ALL;
            KIND_RAISE:   in_cmd.op = OP_RAISE;
            KIND_LOWER:   in_cmd.op = OP_LOWER;
            KIND_EMIT:    in_cmd.op = OP_EMIT;
            default:
            begin
                in_cmd.op = OP_EMIT;
                keep      = 1'b0;
            end
        endcase
    end

    assign s_tready = (count_reg != 2'(DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready && keep;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'(DEPTH))
        else $error("Command queue count exceeds its depth.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Full command queue has mismatched pointers.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Empty command queue has mismatched pointers.");

endmodule

// ===== hdl/lsfe_back.sv =====
// Command back end: LED table memory, sequencer for bulk updates and frame output register.
// Depends on lsfe_pkg.
module lsfe_back
    import lsfe_pkg::*;
#(
    parameter int LED_COUNT = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  cmd_t                   q_cmd,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // frame_word
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    localparam int IDX_W = (LED_COUNT > 2) ? $clog2(LED_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(LED_COUNT - 1);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_FILL      = 6'b000010,
        ST_ADJUST    = 6'b000100,
        ST_EMIT_HEAD = 6'b001000,
        ST_EMIT_BODY = 6'b010000,
        ST_EMIT_TAIL = 6'b100000
    } state_t;

    function automatic logic [COLOR_W-1:0] sat_add(input logic [COLOR_W-1:0] v,
                                                   input logic [COLOR_W-1:0] d);
        logic [COLOR_W:0] s;
        s = {1'b0, v} + {1'b0, d};
        return s[COLOR_W] ? COLOR_MAX : s[COLOR_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] sat_sub(input logic [COLOR_W-1:0] v,
                                                   input logic [COLOR_W-1:0] d);
        return (v > d) ? (v - d) : '0;
    endfunction

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              rd_more_reg, rd_more_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]  wr_addr_reg, wr_addr_next;

    entry_t            mem [LED_COUNT];
    logic [LED_COUNT-1:0] valid_reg;
    entry_t            rdata_reg;
    logic              rvalid_reg;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;
    logic                   can_load;
    logic                   out_load;
    logic [OUT_TDATA_W-1:0] load_data;
    logic                   load_last;

    entry_t                 read_entry;
    entry_t                 adj_entry;
    entry_t                 fill_entry;
    logic [OUT_TDATA_W-1:0] led_word;

    assign can_load   = !out_valid_reg || m_tready;
    assign read_entry = rvalid_reg ? rdata_reg : '0;
    assign led_word   = {LED_WORD_MARK | {3'b000, read_entry.bright},
                         read_entry.blue, read_entry.green, read_entry.red};

    always_comb
    begin
        fill_entry.bright = cmd_reg.bright;
        fill_entry.red    = cmd_reg.red;
        fill_entry.green  = cmd_reg.green;
        fill_entry.blue   = cmd_reg.blue;
        adj_entry.bright  = read_entry.bright;
        if (cmd_reg.op == OP_RAISE)
        begin
            adj_entry.red   = sat_add(read_entry.red, cmd_reg.red);
            adj_entry.green = sat_add(read_entry.green, cmd_reg.green);
            adj_entry.blue  = sat_add(read_entry.blue, cmd_reg.blue);
        end
        else
        begin
            adj_entry.red   = sat_sub(read_entry.red, cmd_reg.red);
            adj_entry.green = sat_sub(read_entry.green, cmd_reg.green);
            adj_entry.blue  = sat_sub(read_entry.blue, cmd_reg.blue);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        rd_more_next = rd_more_reg;
        wr_pend_next = wr_pend_reg;
        wr_addr_next = wr_addr_reg;
        q_ready      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = fill_entry;
        mem_re       = 1'b0;
        mem_raddr    = addr_reg;
        out_load     = 1'b0;
        load_data    = '0;
        load_last    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    cmd_next = q_cmd;
                    case (q_cmd.op)
                        OP_SET_ONE:
                        begin
                            mem_we           = 1'b1;
                            mem_waddr        = IDX_W'(q_cmd.led_index);
                            mem_wdata.bright = q_cmd.bright;
                            mem_wdata.red    = q_cmd.red;
                            mem_wdata.green  = q_cmd.green;
                            mem_wdata.blue   = q_cmd.blue;
                        end
                        OP_SET_ALL:
                        begin
                            addr_next  = IDX_W'(1);
                            state_next = ST_FILL;
                        end
                        OP_RAISE, OP_LOWER:
                        begin
                            addr_next    = IDX_W'(1);
                            rd_more_next = 1'b1;
                            wr_pend_next = 1'b0;
                            state_next   = ST_ADJUST;
                        end
                        OP_EMIT:
                        begin
                            addr_next  = '0;
                            state_next = ST_EMIT_HEAD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            ST_ADJUST:
            begin
                if (wr_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = adj_entry;
                end
                if (rd_more_reg)
                begin
                    mem_re       = 1'b1;
                    wr_pend_next = 1'b1;
                    wr_addr_next = addr_reg;
                    if (addr_reg == LAST_ADDR)
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        addr_next = addr_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT_HEAD:
            begin
                if (can_load)
                begin
                    out_load     = 1'b1;
                    mem_re       = 1'b1;
                    addr_next    = IDX_W'(1);
                    rd_more_next = 1'b1;
                    state_next   = ST_EMIT_BODY;
                end
            end
            ST_EMIT_BODY:
            begin
                if (can_load)
                begin
                    out_load  = 1'b1;
                    load_data = led_word;
                    if (rd_more_reg)
                    begin
                        mem_re = 1'b1;
                        if (addr_reg == LAST_ADDR)
                        begin
                            rd_more_next = 1'b0;
                        end
                        else
                        begin
                            addr_next = addr_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        state_next = ST_EMIT_TAIL;
                    end
                end
            end
            ST_EMIT_TAIL:
            begin
                if (can_load)
                begin
                    out_load   = 1'b1;
                    load_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            rd_more_reg   <= 1'b0;
            wr_pend_reg   <= 1'b0;
            wr_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            rd_more_reg <= rd_more_next;
            wr_pend_reg <= wr_pend_next;
            wr_addr_reg <= wr_addr_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (out_load)
        begin
            out_data_reg <= load_data;
            out_last_reg <= load_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                rvalid_reg <= valid_reg[mem_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("Table read and write collide on one entry.");
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(mem_waddr) < LED_COUNT))
        else $error("Table write beyond the last LED.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_data_reg == '0))
        else $error("Final frame word is not the zero end word.");
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ADJUST) && !rd_more_reg) |-> wr_pend_reg)
        else $error("Adjust pass ends without its final write-back.");

endmodule

// ===== hdl/led_strip_frame_store_emitter_top.sv =====
// Top level of the LED strip frame store and emitter.
// Depends on lsfe_pkg, lsfe_front and lsfe_back.
//
// Commands enter on the s_axis channel, one per transfer: set one LED, set all LEDs
// except LED 0, raise or lower the colors of all LEDs except LED 0 with saturation, or
// emit a frame. Unknown kinds and set-one commands past the last LED are dropped.
// Frame words leave on the m_axis channel: a zero start word, one word per LED with
// 0xE0 or brightness in the top byte followed by blue, green and red, and a zero end
// word marked by m_axis_tlast.
// A two-entry command queue separates the input from the table sequencer, so commands
// keep being accepted while a frame is still draining.
// Set one writes its single entry; set all and raise or lower walk the table one
// entry per cycle, raise and lower reading each entry and writing back the adjusted
// value through separate read and write ports. An emit puts a start word on m_axis,
// then one word per cycle while m_axis_tready is high, LED_COUNT + 2 in all, paced by
// the table read port and the output register.
// When the receiver holds m_axis_tready low, the current word stays on the port and the
// table walk pauses; the queue then fills and s_axis_tready drops.
// Reset clears every LED entry to zero, empties the queue and drops any partial frame.
module led_strip_frame_store_emitter_top
    import lsfe_pkg::*;
#(
    parameter int LED_COUNT = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // kind, led_index, bright_level, red_value, green_value, blue_value, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // frame_word
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    lsfe_front #(
        .LED_COUNT(LED_COUNT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_axis_tvalid),
        .s_tready(s_axis_tready),
        .s_tdata (s_axis_tdata),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    lsfe_back #(
        .LED_COUNT(LED_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_tvalid(m_axis_tvalid),
        .m_tready(m_axis_tready),
        .m_tdata (m_axis_tdata),
        .m_tlast (m_axis_tlast)
    );

endmodule
